### src/srdf_pkg.sv
// ----------------------------------------------------------------------------
// srdf_pkg
// Shared constants, command codes and types for the S1 record data framer.
// ----------------------------------------------------------------------------
package srdf_pkg;

    // Data bytes held per record before it is sent.
    localparam int RECORD_DATA_MAX = 31;

    // Width of a fill count that can reach RECORD_DATA_MAX.
    localparam int FILL_W = $clog2(RECORD_DATA_MAX + 1);
    // Address width of the data store.
    localparam int STORE_AW = (RECORD_DATA_MAX > 1) ? $clog2(RECORD_DATA_MAX) : 1;
    // Word index within a record: count, two address words, data, checksum.
    localparam int IDX_W = $clog2(RECORD_DATA_MAX + 4);

    // Count word offset: address high, address low, checksum.
    localparam logic [7:0] COUNT_OFFSET = 8'd3;

    // Queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;
    localparam int QUEUE_CW = 2;

    // Input operation codes.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Command kinds from front to back.
    localparam logic [1:0] CMD_APPEND      = 2'd0;
    localparam logic [1:0] CMD_APPEND_SEND = 2'd1;
    localparam logic [1:0] CMD_FLUSH_SEND  = 2'd2;
    localparam logic [1:0] CMD_SET_ADDR    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] address;
    } t_cmd;

    typedef struct packed {
        logic              idle;
        logic [FILL_W-1:0] fill;
    } t_back_status;

endpackage

### src/srdf_front.sv
// ----------------------------------------------------------------------------
// srdf_front
// Accepts input words and turns each into a back-end command, tracking the
// fill level so that record boundaries are known up front.
// ----------------------------------------------------------------------------
module srdf_front
    import srdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  logic [15:0]       i_address,
    output logic              o_stall,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd,
    output logic [FILL_W-1:0] o_shadow_fill
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              w_accept;
    logic              w_fills;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_fills  = (r_fill + FILL_W'(1)) == FILL_W'(RECORD_DATA_MAX);

    always_comb begin
        n_fill          = r_fill;
        o_cmd.data_byte = i_data_byte;
        o_cmd.address   = i_address;
        o_cmd.kind      = CMD_APPEND;
        case (i_op)
            OP_APPEND: begin
                if (w_fills) begin
                    // next record starts right after this byte
                    o_cmd.kind    = CMD_APPEND_SEND;
                    o_cmd.address = i_address + 16'd1;
                    n_fill        = '0;
                end else begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            OP_FLUSH: begin
                o_cmd.kind = (r_fill != '0) ? CMD_FLUSH_SEND : CMD_SET_ADDR;
                n_fill     = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    assign o_push        = w_accept;
    assign o_shadow_fill = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

endmodule

### src/srdf_fifo.sv
// ----------------------------------------------------------------------------
// srdf_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module srdf_fifo
    import srdf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_cmd                i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output t_cmd                o_cmd,
    output logic [QUEUE_CW-1:0] o_count
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign o_count = r_count;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/srdf_back.sv
// ----------------------------------------------------------------------------
// srdf_back
// Holds the record data, running sum and start address, and sends each
// record word by word through an output register.
// ----------------------------------------------------------------------------
module srdf_back
    import srdf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    output logic         o_valid,
    output logic [7:0]   o_record_byte,
    output logic         o_last,
    input  logic         i_stall,
    output t_back_status o_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [7:0]          r_store [RECORD_DATA_MAX];
    logic [1:0]          r_state;
    logic [FILL_W-1:0]   r_fill;
    logic [7:0]          r_sum;
    logic [15:0]         r_start;
    logic [15:0]         r_next_addr;
    logic [7:0]          r_cks;
    logic [IDX_W-1:0]    r_idx;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic                w_take;
    logic                w_append;
    logic                w_emit;
    logic [7:0]          w_count;
    logic [IDX_W-1:0]    w_last_idx;
    logic [STORE_AW-1:0] w_rd_addr;
    logic [7:0]          w_byte;
    logic                w_is_last;
    logic                w_from_store;

    assign w_take   = (r_state == ST_IDLE) && i_q_valid;
    assign o_pop    = w_take;
    assign w_append = w_take &&
                      (i_cmd.kind == CMD_APPEND || i_cmd.kind == CMD_APPEND_SEND);
    assign w_emit   = (r_state == ST_SEND) && (!r_out_valid || !i_stall);

    assign w_count      = 8'(r_fill) + COUNT_OFFSET;
    assign w_last_idx   = IDX_W'(r_fill) + IDX_W'(3);
    assign w_rd_addr    = STORE_AW'(r_idx - IDX_W'(3));
    assign w_is_last    = r_idx == w_last_idx;
    assign w_from_store = (r_idx >= IDX_W'(3)) && !w_is_last;

    always_comb begin
        case (r_idx)
            IDX_W'(0): w_byte = w_count;
            IDX_W'(1): w_byte = r_start[15:8];
            IDX_W'(2): w_byte = r_start[7:0];
            default:   w_byte = r_cks;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_store[r_fill[STORE_AW-1:0]] <= i_cmd.data_byte;
        end
        if (w_emit) begin
            if (w_from_store) begin
                r_out_byte <= r_store[w_rd_addr];
            end else begin
                r_out_byte <= w_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_last <= w_is_last;
        end
        if (r_state == ST_PREP) begin
            r_cks <= ~(w_count + r_start[15:8] + r_start[7:0] + r_sum);
        end
        if (w_take) begin
            r_next_addr <= i_cmd.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_start     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_append) begin
                        r_fill <= r_fill + FILL_W'(1);
                        r_sum  <= r_sum + i_cmd.data_byte;
                    end
                    if (w_take) begin
                        case (i_cmd.kind)
                            CMD_APPEND_SEND: r_state <= ST_PREP;
                            CMD_FLUSH_SEND:  r_state <= ST_PREP;
                            CMD_SET_ADDR:    r_start <= i_cmd.address;
                            default:         r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_PREP: begin
                    r_idx   <= '0;
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (w_emit) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (w_is_last) begin
                            // record done: clear and advance the start address
                            r_fill  <= '0;
                            r_sum   <= '0;
                            r_start <= r_next_addr;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_record_byte = r_out_byte;
    assign o_last        = r_out_last;

    assign o_status.idle = r_state == ST_IDLE;
    assign o_status.fill = r_fill;

endmodule

### src/s_record_data_framer.sv
// ----------------------------------------------------------------------------
// s_record_data_framer
// Packs data bytes into S1 records (16-bit address) and sends each record as
// binary words: count, address high, address low, data, checksum.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -------------------------------
//  input     in         i_valid / o_stall     i_op, i_data_byte, i_address
//  output    out        o_valid / i_stall     o_record_byte, o_last
//
//  The front classifies each input word in the cycle it is accepted and
//  pushes a command into a two-entry queue; the back executes commands.
//  An append that does not close a record is taken by the back while idle.
//  A record of n data bytes is sent by taking the command, forming the
//  checksum, then emitting its n + 4 output words; the back takes no new
//  command until the last word has been emitted.
//  Reset is synchronous and active low; it clears fill count, running sum,
//  start address, queue and output valid. The data store is not cleared.
//  o_stall rises while the queue is full; an output stall holds the back.
//
module s_record_data_framer
    import srdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_address,
    output logic        o_stall,
    output logic        o_valid,
    output logic [7:0]  o_record_byte,
    output logic        o_last,
    input  logic        i_stall
);

    // front -> queue
    logic                w_push;
    t_cmd                w_push_cmd;
    logic [FILL_W-1:0]   w_shadow_fill;
    // queue -> back
    logic                w_q_full;
    logic                w_q_valid;
    t_cmd                w_q_cmd;
    logic [QUEUE_CW-1:0] w_q_count;
    logic                w_pop;
    t_back_status        w_back_status;

    // Classify input words and track record boundaries.
    srdf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_address    (i_address),
        .o_stall      (o_stall),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .o_shadow_fill(w_shadow_fill)
    );

    // Decouple front from back so each can stall on its own.
    srdf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .i_pop  (w_pop),
        .o_full (w_q_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_q_cmd),
        .o_count(w_q_count)
    );

    // Store data, keep the sum, and send records.
    srdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_record_byte(o_record_byte),
        .o_last       (o_last),
        .i_stall      (i_stall),
        .o_status     (w_back_status)
    );

`ifndef SYNTHESIS
    // Queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue overflow");

    // Front never lets a record fill without closing it.
    a_front_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shadow_fill < FILL_W'(RECORD_DATA_MAX))
        else $error("front fill count out of range");

    // With nothing in flight, front and back agree on the fill level.
    a_fill_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_back_status.idle && !w_q_valid) |-> (w_shadow_fill == w_back_status.fill))
        else $error("front and back fill counts disagree");
`endif

endmodule
